// ----- design/i2c_mra_pkg.sv -----
package i2c_mra_pkg;

  localparam int unsigned KindW     = 2;
  localparam int unsigned DevW      = 7;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned TimerW    = 16;
  localparam int unsigned BitIdxW   = 4;
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 16;

  // operation codes
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // transaction kinds
  localparam logic [KindW-1:0] KindWrite    = 2'd0;
  localparam logic [KindW-1:0] KindReadByte = 2'd1;
  localparam logic [KindW-1:0] KindReadWord = 2'd2;
  localparam logic [KindW-1:0] KindReserved = 2'd3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgPhaseLength = 4'd0;
  localparam logic [CfgIndexW-1:0] CfgAbortOnNack = 4'd1;

  localparam logic [TimerW-1:0]  PhaseLengthReset = 16'd40;
  localparam logic [ByteW-1:0]   MsbMask          = 8'h80;
  localparam logic [BitIdxW-1:0] AckSlot          = 4'd8;

  typedef enum logic [9:0] {
    PhIdle   = 10'b00_0000_0001,
    PhStart1 = 10'b00_0000_0010,
    PhDevW   = 10'b00_0000_0100,
    PhRegB   = 10'b00_0000_1000,
    PhDataW  = 10'b00_0001_0000,
    PhStart2 = 10'b00_0010_0000,
    PhDevR   = 10'b00_0100_0000,
    PhRd0    = 10'b00_1000_0000,
    PhRd1    = 10'b01_0000_0000,
    PhStop   = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             busy_res;
    logic             done_res;
    logic [WordW-1:0] read_data;
    logic             nack_seen;
  } result_t;

endpackage

// ----- design/i2c_mra_ifs.sv -----
interface i2c_mra_in_if;
  import i2c_mra_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [KindW-1:0] kind;
  logic [DevW-1:0]  device_address;
  logic [ByteW-1:0] register_address;
  logic [ByteW-1:0] write_data;
  logic             sda_in;

  modport source (output valid, operation, kind, device_address, register_address,
                  write_data, sda_in, input ready);
  modport sink   (input valid, operation, kind, device_address, register_address,
                  write_data, sda_in, output ready);
endinterface

interface i2c_mra_out_if;
  import i2c_mra_pkg::*;

  logic             valid;
  logic             ready;
  logic             scl_level;
  logic             sda_level;
  logic             busy_res;
  logic             done_res;
  logic [WordW-1:0] read_data;
  logic             nack_seen;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                  nack_seen, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                  nack_seen, output ready);
endinterface

interface i2c_mra_cfg_if;
  import i2c_mra_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/i2c_master_register_access.sv -----
// I2C master for single register access: write byte, read byte, read word.
// Channels:
//   in_i  - one transaction per item: either a timer tick (carrying the sampled
//           SDA level) or a start command (kind, device, register, write byte).
//   out_o - one result per input item: SCL/SDA line levels, busy, done on the
//           tick that completes STOP, the read word and the sticky NACK flag.
//   cfg_i - register writes: index 0 phase_length, index 1 abort_on_nack.
//           Always ready; other indexes are dropped.
// Throughput: one item per clock while the output buffer has room. Each accepted
// item steps the bus sequencer once in combinational logic; its result is then
// registered into the output buffer.
// A two-entry output buffer decouples the sides: the input stays ready while
// one result waits, and drops ready only when both entries are occupied by a
// stalled receiver. Results are held unchanged until taken.
// Reset: lines released high, sequencer idle, phase_length 40, abort off,
// output buffer empty.
module i2c_master_register_access (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2c_mra_in_if.sink    in_i,
  i2c_mra_cfg_if.sink   cfg_i,
  i2c_mra_out_if.source out_o
);
  import i2c_mra_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TimerW-1:0] phase_len_q;
  logic              abort_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_len_q <= PhaseLengthReset;
      abort_q     <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgPhaseLength: phase_len_q <= cfg_i.data[TimerW-1:0];
        CfgAbortOnNack: abort_q     <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [TimerW-1:0]  timer_q, timer_d;
  phase_e             phase_q, phase_d;
  logic [1:0]         quarter_q, quarter_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [WordW-1:0]   word_q, word_d;
  logic               nack_q, nack_d;
  logic               busy_q, busy_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic [KindW-1:0]   kind_q, kind_d;
  logic [DevW-1:0]    dev_q, dev_d;
  logic [ByteW-1:0]   reg_q, reg_d;
  logic [ByteW-1:0]   data_q, data_d;
  logic               done;

  function automatic logic is_send(phase_e ph);
    return (ph == PhDevW) || (ph == PhRegB) || (ph == PhDataW) || (ph == PhDevR);
  endfunction

  function automatic logic is_byte(phase_e ph);
    return is_send(ph) || (ph == PhRd0) || (ph == PhRd1);
  endfunction

  // Line levels after entering a given step; returns {scl, sda}.
  function automatic logic [1:0] line_levels(phase_e ph, logic [1:0] q,
                                             logic [BitIdxW-1:0] bidx,
                                             logic [ByteW-1:0] sh,
                                             logic [KindW-1:0] knd,
                                             logic scl, logic sda);
    logic scl_n, sda_n, drv;
    scl_n = scl;
    sda_n = sda;
    if (bidx < AckSlot) begin
      drv = is_send(ph) ? ((sh & MsbMask) != '0) : 1'b1;
    end else begin
      drv = (ph == PhRd0 && knd == KindReadWord) ? 1'b0 : 1'b1;
    end
    if (ph == PhStart1 || ph == PhStart2) begin
      scl_n = (q == 2'd1) || (q == 2'd2);
      sda_n = (q <= 2'd1);
    end else if (ph == PhStop) begin
      scl_n = (q >= 2'd2);
      if (q == 2'd1 || q == 2'd2) sda_n = 1'b0;
      if (q == 2'd3) sda_n = 1'b1;
    end else if (is_byte(ph)) begin
      if (q == 2'd0) scl_n = 1'b0;
      else if (q == 2'd1) sda_n = drv;
      else if (q == 2'd2) scl_n = 1'b1;
    end
    return {scl_n, sda_n};
  endfunction

  logic [TimerW:0] tick_cnt;
  logic            stop_now;
  phase_e          next_ph;

  always_comb begin
    timer_d   = timer_q;
    phase_d   = phase_q;
    quarter_d = quarter_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    word_d    = word_q;
    nack_d    = nack_q;
    busy_d    = busy_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    kind_d    = kind_q;
    dev_d     = dev_q;
    reg_d     = reg_q;
    data_d    = data_q;
    done      = 1'b0;
    tick_cnt  = {1'b0, timer_q} + 1'b1;
    stop_now  = 1'b0;
    next_ph   = PhStop;

    if (in_i.operation == OpStart) begin
      // Ignore commands while busy and the reserved kind
      if (!busy_q && in_i.kind != KindReserved) begin
        kind_d    = in_i.kind;
        dev_d     = in_i.device_address;
        reg_d     = in_i.register_address;
        data_d    = in_i.write_data;
        word_d    = '0;
        nack_d    = 1'b0;
        busy_d    = 1'b1;
        timer_d   = '0;
        phase_d   = PhStart1;
        quarter_d = 2'd0;
        bit_idx_d = '0;
        {scl_d, sda_d} = line_levels(PhStart1, 2'd0, '0, shift_d, kind_d, scl_d, sda_d);
      end
    end else if (busy_q) begin
      if (tick_cnt >= {1'b0, phase_len_q}) begin
        timer_d = '0;
        // Sample SDA at the end of the SCL high quarter
        if (is_byte(phase_q) && quarter_q == 2'd2) begin
          if (bit_idx_q < AckSlot && !is_send(phase_q)) begin
            shift_d = {shift_q[ByteW-2:0], in_i.sda_in};
          end else if (bit_idx_q >= AckSlot && is_send(phase_q) && in_i.sda_in) begin
            nack_d = 1'b1;
          end
        end
        if (quarter_q != 2'd3) begin
          quarter_d = quarter_q + 2'd1;
          {scl_d, sda_d} = line_levels(phase_q, quarter_d, bit_idx_q, shift_d, kind_q,
                                       scl_q, sda_q);
        end else if (is_byte(phase_q) && bit_idx_q < AckSlot) begin
          // Advance to the next bit of the byte
          if (is_send(phase_q)) shift_d = {shift_q[ByteW-2:0], 1'b0};
          bit_idx_d = bit_idx_q + 1'b1;
          quarter_d = 2'd0;
          {scl_d, sda_d} = line_levels(phase_q, 2'd0, bit_idx_d, shift_d, kind_q,
                                       scl_q, sda_q);
        end else begin
          stop_now = is_send(phase_q) && abort_q && nack_q;
          case (phase_q)
            PhStart1: next_ph = PhDevW;
            PhDevW:   next_ph = PhRegB;
            PhRegB:   next_ph = (kind_q == KindWrite) ? PhDataW : PhStart2;
            PhStart2: next_ph = PhDevR;
            PhDevR:   next_ph = PhRd0;
            PhRd0: begin
              word_d  = {word_q[WordW-1:ByteW], shift_q};
              next_ph = (kind_q == KindReadWord) ? PhRd1 : PhStop;
            end
            PhRd1: begin
              word_d  = {shift_q, word_q[ByteW-1:0]};
              next_ph = PhStop;
            end
            default:  next_ph = PhStop;
          endcase
          if (stop_now) next_ph = PhStop;
          if (phase_q == PhStop) begin
            // STOP complete: release the bus and go idle
            phase_d   = PhIdle;
            quarter_d = 2'd0;
            bit_idx_d = '0;
            busy_d    = 1'b0;
            scl_d     = 1'b1;
            sda_d     = 1'b1;
            done      = 1'b1;
          end else begin
            phase_d   = next_ph;
            quarter_d = 2'd0;
            bit_idx_d = '0;
            case (next_ph)
              PhDevW:  shift_d = {dev_q, 1'b0};
              PhDevR:  shift_d = {dev_q, 1'b1};
              PhRegB:  shift_d = reg_q;
              PhDataW: shift_d = data_q;
              PhRd0:   shift_d = '0;
              PhRd1:   shift_d = '0;
              default: ;
            endcase
            {scl_d, sda_d} = line_levels(next_ph, 2'd0, '0, shift_d, kind_q, scl_q, sda_q);
          end
        end
      end else begin
        timer_d = tick_cnt[TimerW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry output buffer
  // ---------------------------------------------------------------------------
  logic    head_vld_q, skid_vld_q;
  result_t head_q, skid_q, res;
  logic    in_acc, out_acc;

  assign in_i.ready = !skid_vld_q;
  assign in_acc     = in_i.valid && !skid_vld_q;
  assign out_acc    = head_vld_q && out_o.ready;

  assign res = '{scl_level: scl_d, sda_level: sda_d, busy_res: busy_d, done_res: done,
                 read_data: word_d, nack_seen: nack_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q   <= '0;
      phase_q   <= PhIdle;
      quarter_q <= 2'd0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      word_q    <= '0;
      nack_q    <= 1'b0;
      busy_q    <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      kind_q    <= KindWrite;
      dev_q     <= '0;
      reg_q     <= '0;
      data_q    <= '0;
    end else if (in_acc) begin
      timer_q   <= timer_d;
      phase_q   <= phase_d;
      quarter_q <= quarter_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      word_q    <= word_d;
      nack_q    <= nack_d;
      busy_q    <= busy_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      kind_q    <= kind_d;
      dev_q     <= dev_d;
      reg_q     <= reg_d;
      data_q    <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        if (!head_vld_q || (out_acc && !skid_vld_q)) begin
          head_vld_q <= 1'b1;
        end else if (!out_acc) begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_acc) begin
        head_vld_q <= skid_vld_q;
        skid_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!head_vld_q || (out_acc && !skid_vld_q)) begin
        head_q <= res;
      end else if (!out_acc) begin
        skid_q <= res;
      end
    end else if (out_acc) begin
      head_q <= skid_q;
    end
  end

  assign out_o.valid     = head_vld_q;
  assign out_o.scl_level = head_q.scl_level;
  assign out_o.sda_level = head_q.sda_level;
  assign out_o.busy_res  = head_q.busy_res;
  assign out_o.done_res  = head_q.done_res;
  assign out_o.read_data = head_q.read_data;
  assign out_o.nack_seen = head_q.nack_seen;

endmodule
